### rtl/mmlr_pkg.sv
// Shared constants, register map and config struct for the mono mix resampler.
// No dependencies; imported by the interfaces, mmlr_cfg and the top level.
`default_nettype none

package mmlr_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int MAX_CHANNELS    = 8;

  localparam int STEP_BITS  = 24;
  localparam int GAIN_BITS  = 16;
  localparam int FRAME_BITS = 24;
  localparam int MIX_SHIFT  = 15;
  localparam int PHASE_BITS = 26;

  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_CHANNELS);
  localparam int MUL_A_BITS = (SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS + 1;
  localparam int MUL_B_BITS = ((GAIN_BITS > PHASE_FRAC_BITS) ? GAIN_BITS : PHASE_FRAC_BITS) + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  localparam longint SMP_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam longint SUM_MAX = longint'(MAX_CHANNELS) * (SMP_MAX + 1) - 1;
  localparam longint SUM_MIN = -longint'(MAX_CHANNELS) * (SMP_MAX + 1);

  localparam longint MIN_STEP = longint'(1) << (PHASE_FRAC_BITS - 5);
  localparam longint ONE_PHASE = longint'(1) << PHASE_FRAC_BITS;

  // APB register map
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 4;
  localparam int IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] REG_STEP_RATIO = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_MIX_GAIN   = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_BYPASS     = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_MAX_FRAMES = 2'd3;

  localparam logic [STEP_BITS-1:0]  STEP_RESET   = STEP_BITS'(65536);
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET   = GAIN_BITS'(32768);
  localparam logic [FRAME_BITS-1:0] FRAMES_RESET = FRAME_BITS'(16777215);

  typedef struct packed {
    logic [STEP_BITS-1:0]  step_ratio;
    logic [GAIN_BITS-1:0]  mix_gain;
    logic                  bypass;
    logic [FRAME_BITS-1:0] max_input_frames;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/mmlr_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on mmlr_pkg for the sample width.
`default_nettype none

interface mmlr_in_if;
  import mmlr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] channel_sample;
  logic                          frame_end;
  logic                          stream_end;

  modport source (output valid, output channel_sample, output frame_end,
                  output stream_end, input ready);
  modport sink (input valid, input channel_sample, input frame_end,
                input stream_end, output ready);
endinterface

interface mmlr_out_if;
  import mmlr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          run_last;
  logic                          stream_done;

  modport source (output valid, output out_sample, output run_last,
                  output stream_done, input ready);
  modport sink (input valid, input out_sample, input run_last,
                input stream_done, output ready);
endinterface

`default_nettype wire

### rtl/mono_mix_linear_resampler.sv
// Mono mix-down and linear-interpolation resampler; one shared multiplier under a sequencer.
// Channel items are summed while idle. A frame-end item is mixed (S_MIX, S_MONO), then each
// interpolated result is a multiply (S_LMUL), then add/round/saturate (S_LOUT). Held-sample
// tail results and bypass results wait only on a free output. Input ready only while the
// sequencer is idle. Reset (rst_ni low, asynchronous) clears sums, held sample, phase and
// frame count, and loads the register defaults. Depends on mmlr_pkg, mmlr_if and mmlr_cfg.
`default_nettype none

module mono_mix_linear_resampler (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mmlr_in_if.sink                             in_i,
  mmlr_out_if.source                          out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mmlr_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [mmlr_pkg::DATA_BITS-1:0] pwdata,
  output logic      [mmlr_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready
);
  import mmlr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MIX  = 4'd1;
  localparam logic [3:0] S_MONO = 4'd2;
  localparam logic [3:0] S_LCHK = 4'd3;
  localparam logic [3:0] S_LMUL = 4'd4;
  localparam logic [3:0] S_LOUT = 4'd5;
  localparam logic [3:0] S_HOLD = 4'd6;
  localparam logic [3:0] S_TAIL = 4'd7;
  localparam logic [3:0] S_BYP  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  localparam logic signed [SUM_BITS:0]    SUM_HI  = (SUM_BITS+1)'(SUM_MAX);
  localparam logic signed [SUM_BITS:0]    SUM_LO  = (SUM_BITS+1)'(SUM_MIN);
  localparam logic signed [PROD_BITS-1:0] P_S_HI  = PROD_BITS'(SMP_MAX);
  localparam logic signed [PROD_BITS-1:0] P_S_LO  = PROD_BITS'(SMP_MIN);
  localparam logic signed [PROD_BITS-1:0] MIX_RND = PROD_BITS'(longint'(1) << (MIX_SHIFT - 1));
  localparam logic signed [PROD_BITS-1:0] LRP_RND =
    PROD_BITS'(longint'(1) << (PHASE_FRAC_BITS - 1));
  localparam logic [PHASE_BITS-1:0] ONE = PHASE_BITS'(ONE_PHASE);
  localparam logic [PHASE_BITS-1:0] TWO = PHASE_BITS'(2 * ONE_PHASE);
  localparam logic [STEP_BITS-1:0]  STEP_MIN = STEP_BITS'(MIN_STEP);

  cfg_t cfg;

  mmlr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [3:0]                    state_q, state_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] held_q, held_d;
  logic signed [SAMPLE_BITS-1:0] mono_q, mono_d;
  logic                          have_held_q, have_held_d;
  logic [PHASE_BITS-1:0]         phase_q, phase_d;
  logic [FRAME_BITS-1:0]         fc_q, fc_d;
  logic                          disc_q, disc_d;
  logic                          last_q, last_d;
  logic                          send_q, send_d;
  logic signed [PROD_BITS-1:0]   prod_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q, out_smp_n;
  logic                          out_rl_q, out_rl_n;
  logic                          out_done_q, out_done_n;
  logic                          out_load, out_free;

  logic                          in_acc;
  logic signed [SUM_BITS:0]      sum_ext;
  logic signed [SUM_BITS-1:0]    sum_sat;
  logic signed [PROD_BITS-1:0]   mono_full, lerp_full;
  logic signed [SAMPLE_BITS-1:0] mono_sat, lerp_sat;
  logic [FRAME_BITS-1:0]         fc_inc;
  logic                          last_w;
  logic [STEP_BITS-1:0]          step_w;
  logic [PHASE_BITS-1:0]         nphase;
  logic                          lerp_rl;
  logic                          mul_en;
  logic signed [MUL_A_BITS-1:0]  mul_a;
  logic signed [MUL_B_BITS-1:0]  mul_b;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.out_sample  = out_smp_q;
  assign out_o.run_last    = out_rl_q;
  assign out_o.stream_done = out_done_q;

  // Channel accumulation, saturated at the channel-count full scale
  assign sum_ext = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(in_i.channel_sample);
  always_comb begin
    if (sum_ext > SUM_HI)      sum_sat = SUM_BITS'(SUM_HI);
    else if (sum_ext < SUM_LO) sum_sat = SUM_BITS'(SUM_LO);
    else                       sum_sat = sum_ext[SUM_BITS-1:0];
  end

  // Shared multiplier: mix gain in S_MIX, interpolation weight in S_LMUL
  assign mul_a = (state_q == S_MIX) ? MUL_A_BITS'(sum_q)
                                    : MUL_A_BITS'(mono_q) - MUL_A_BITS'(held_q);
  assign mul_b = (state_q == S_MIX) ? MUL_B_BITS'({1'b0, cfg.mix_gain})
                                    : MUL_B_BITS'({1'b0, phase_q[PHASE_FRAC_BITS-1:0]});

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  end

  assign mono_full = (prod_q + MIX_RND) >>> MIX_SHIFT;
  always_comb begin
    if (mono_full > P_S_HI)      mono_sat = SAMPLE_BITS'(P_S_HI);
    else if (mono_full < P_S_LO) mono_sat = SAMPLE_BITS'(P_S_LO);
    else                         mono_sat = mono_full[SAMPLE_BITS-1:0];
  end

  assign lerp_full = PROD_BITS'(held_q) + ((prod_q + LRP_RND) >>> PHASE_FRAC_BITS);
  always_comb begin
    if (lerp_full > P_S_HI)      lerp_sat = SAMPLE_BITS'(P_S_HI);
    else if (lerp_full < P_S_LO) lerp_sat = SAMPLE_BITS'(P_S_LO);
    else                         lerp_sat = lerp_full[SAMPLE_BITS-1:0];
  end

  assign fc_inc = fc_q + FRAME_BITS'(1);
  assign last_w = send_q || (fc_inc >= cfg.max_input_frames);
  assign step_w = (cfg.step_ratio < STEP_MIN) ? STEP_MIN : cfg.step_ratio;
  assign nphase = phase_q + PHASE_BITS'(step_w);
  // Last result unless another interpolated or tail position follows
  assign lerp_rl = !((nphase < ONE) || (last_q && (nphase < TWO)));

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    held_d      = held_q;
    mono_d      = mono_q;
    have_held_d = have_held_q;
    phase_d     = phase_q;
    fc_d        = fc_q;
    disc_d      = disc_q;
    last_d      = last_q;
    send_d      = send_q;
    mul_en      = 1'b0;
    out_load    = 1'b0;
    out_smp_n   = mono_q;
    out_rl_n    = 1'b1;
    out_done_n  = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (disc_q) begin
            if (in_i.frame_end && in_i.stream_end) disc_d = 1'b0;
          end else begin
            sum_d = sum_sat;
            if (in_i.frame_end) begin
              send_d  = in_i.stream_end;
              state_d = S_MIX;
            end
          end
        end
      end
      S_MIX: begin
        mul_en  = 1'b1;
        state_d = S_MONO;
      end
      S_MONO: begin
        mono_d = mono_sat;
        sum_d  = '0;
        fc_d   = fc_inc;
        last_d = last_w;
        if (last_w && !send_q) disc_d = 1'b1;
        if (cfg.bypass)       state_d = S_BYP;
        else if (have_held_q) state_d = S_LCHK;
        else                  state_d = S_HOLD;
      end
      S_LCHK: begin
        if (phase_q < ONE) begin
          state_d = S_LMUL;
        end else begin
          phase_d = phase_q - ONE;
          state_d = S_HOLD;
        end
      end
      S_LMUL: begin
        mul_en  = 1'b1;
        state_d = S_LOUT;
      end
      S_LOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_smp_n  = lerp_sat;
          out_rl_n   = lerp_rl;
          out_done_n = lerp_rl && last_q;
          if (nphase < ONE) begin
            phase_d = nphase;
            state_d = S_LMUL;
          end else begin
            phase_d = nphase - ONE;
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        held_d      = mono_q;
        have_held_d = 1'b1;
        state_d     = last_q ? S_TAIL : S_FIN;
      end
      S_TAIL: begin
        // Repeat the last sample for positions left past the stream end
        if (phase_q >= ONE) begin
          state_d = S_FIN;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_rl_n   = !(nphase < ONE);
          out_done_n = !(nphase < ONE);
          phase_d    = nphase;
          if (!(nphase < ONE)) state_d = S_FIN;
        end
      end
      S_BYP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (last_q) begin
          sum_d       = '0;
          held_d      = '0;
          have_held_d = 1'b0;
          phase_d     = '0;
          fc_d        = '0;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      held_q      <= '0;
      have_held_q <= 1'b0;
      phase_q     <= '0;
      fc_q        <= '0;
      disc_q      <= 1'b0;
      last_q      <= 1'b0;
      send_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      held_q      <= held_d;
      have_held_q <= have_held_d;
      phase_q     <= phase_d;
      fc_q        <= fc_d;
      disc_q      <= disc_d;
      last_q      <= last_d;
      send_q      <= send_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mono_q <= mono_d;
    if (out_load) begin
      out_smp_q  <= out_smp_n;
      out_rl_q   <= out_rl_n;
      out_done_q <= out_done_n;
    end
  end

  a_lerp_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LMUL || state_q == S_LOUT) |-> (phase_q < ONE))
    else $error("interpolation phase not below one");

  a_frame_to_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.frame_end && !disc_q) |=> (state_q == S_MIX))
    else $error("frame end item did not start mixing");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_done_q || out_rl_q))
    else $error("stream done on a result that is not the last of its item");

  a_empty_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !have_held_q) |-> (phase_q == '0 && held_q == '0))
    else $error("phase or held sample left over with no held sample");

endmodule

`default_nettype wire

### rtl/mmlr_cfg.sv
// APB configuration registers of the resampler, with read-back.
// Depends on mmlr_pkg for the register map and cfg_t.
`default_nettype none

module mmlr_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mmlr_pkg::ADDR_BITS-1:0]   paddr,
  input  wire logic [mmlr_pkg::DATA_BITS-1:0]   pwdata,
  output logic      [mmlr_pkg::DATA_BITS-1:0]   prdata,
  output logic                                  pready,
  output mmlr_pkg::cfg_t                        cfg_o
);
  import mmlr_pkg::*;

  cfg_t                cfg_q, cfg_d;
  logic [IDX_BITS-1:0] idx;
  logic                wr_en;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_STEP_RATIO: cfg_d.step_ratio       = pwdata[STEP_BITS-1:0];
        REG_MIX_GAIN:   cfg_d.mix_gain         = pwdata[GAIN_BITS-1:0];
        REG_BYPASS:     cfg_d.bypass           = pwdata[0];
        REG_MAX_FRAMES: cfg_d.max_input_frames = pwdata[FRAME_BITS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP_RATIO: prdata = DATA_BITS'(cfg_q.step_ratio);
      REG_MIX_GAIN:   prdata = DATA_BITS'(cfg_q.mix_gain);
      REG_BYPASS:     prdata = DATA_BITS'(cfg_q.bypass);
      REG_MAX_FRAMES: prdata = DATA_BITS'(cfg_q.max_input_frames);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_ratio       <= STEP_RESET;
      cfg_q.mix_gain         <= GAIN_RESET;
      cfg_q.bypass           <= 1'b0;
      cfg_q.max_input_frames <= FRAMES_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench for mono_mix_linear_resampler: directed and random channel streams with
// register changes over APB, results checked against an in-bench mix/resample predictor.
// Depends on mmlr_pkg, mmlr_if and the RTL top level.

module tb;
  import mmlr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 250;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          fend;
    logic                          send;
  } chan_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          run_last;
    logic                          stream_done;
  } mono_res_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  mmlr_in_if  in_ch ();
  mmlr_out_if out_ch ();

  mono_mix_linear_resampler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  chan_item_t chan_feed[$];
  mono_res_t  due_samples[$];

  int in_acc_cnt  = 0;
  int in_seen_cnt = 0;
  int in_gap      = 0;
  int out_gap     = 0;
  int hold_req    = 0;
  int hold_left   = 0;
  int idle_cnt    = 0;
  int err_cnt     = 0;
  bit quiet_tail  = 1'b0;

  // Predictor state and register copies
  logic [STEP_BITS-1:0]  cfg_step;
  logic [GAIN_BITS-1:0]  cfg_gain;
  logic                  cfg_bypass;
  logic [FRAME_BITS-1:0] cfg_max_frames;
  longint                m_sum, m_held, m_phase;
  bit                    m_have_held, m_dropping;
  logic [FRAME_BITS-1:0] m_frames;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void clear_stream();
    m_sum = 0;
    m_held = 0;
    m_have_held = 1'b0;
    m_phase = 0;
    m_frames = '0;
  endfunction

  function automatic void mix_and_resample(chan_item_t it);
    longint    mono, step, prod;
    int        n;
    bit        last;
    mono_res_t r;
    n = 0;
    if (m_dropping) begin
      if (it.fend && it.send) m_dropping = 1'b0;
      return;
    end
    m_sum = clamp(m_sum + longint'($signed(it.smp)), SUM_MIN, SUM_MAX);
    if (!it.fend) return;

    mono = clamp((m_sum * longint'(cfg_gain) + 16384) >>> MIX_SHIFT, SMP_MIN, SMP_MAX);
    m_sum = 0;
    m_frames = m_frames + FRAME_BITS'(1);
    last = it.send || (m_frames >= cfg_max_frames);
    if (last && !it.send) m_dropping = 1'b1;

    r.run_last = 1'b0;
    r.stream_done = 1'b0;
    if (cfg_bypass) begin
      r.smp = SAMPLE_BITS'(mono);
      due_samples.push_back(r);
      n++;
    end else begin
      step = (longint'(cfg_step) < MIN_STEP) ? MIN_STEP : longint'(cfg_step);
      if (m_have_held) begin
        while (m_phase < ONE_PHASE && n < 64) begin
          prod = (mono - m_held) * m_phase + (ONE_PHASE >> 1);
          r.smp = SAMPLE_BITS'(clamp(m_held + (prod >>> PHASE_FRAC_BITS), SMP_MIN, SMP_MAX));
          due_samples.push_back(r);
          n++;
          m_phase += step;
        end
        m_phase -= ONE_PHASE;
      end
      m_held = mono;
      m_have_held = 1'b1;
      // repeat the last sample for positions left past the stream end
      if (last) begin
        while (m_phase < ONE_PHASE && n < 64) begin
          r.smp = SAMPLE_BITS'(mono);
          due_samples.push_back(r);
          n++;
          m_phase += step;
        end
      end
    end

    if (n > 0) begin
      due_samples[due_samples.size()-1].run_last = 1'b1;
      due_samples[due_samples.size()-1].stream_done = last;
    end
    if (last) clear_stream();
  endfunction

  // Input driver: offer the head of the feed queue, hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_ch.valid && in_acc_cnt == in_seen_cnt)) begin
        in_seen_cnt = in_acc_cnt;
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 12);
          in_ch.valid <= 1'b0;
        end else if (chan_feed.size() > 0) begin
          in_ch.valid          <= 1'b1;
          in_ch.channel_sample <= chan_feed[0].smp;
          in_ch.frame_end      <= chan_feed[0].fend;
          in_ch.stream_end     <= chan_feed[0].send;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stall bursts plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: check results, predict on accepted items, watch for a hang
  always @(posedge clk_i) begin
    mono_res_t got, want;
    if (rst_ni) begin
      idle_cnt++;
      if (out_ch.valid && out_ch.ready) begin
        idle_cnt = 0;
        got.smp = out_ch.out_sample;
        got.run_last = out_ch.run_last;
        got.stream_done = out_ch.stream_done;
        if (due_samples.size() == 0) begin
          if (err_cnt < 40)
            $display("%0t: unexpected result: sample %0d run_last %0b stream_done %0b",
                     $time, $signed(got.smp), got.run_last, got.stream_done);
          err_cnt++;
        end else begin
          want = due_samples.pop_front();
          if (got.smp !== want.smp || got.run_last !== want.run_last ||
              got.stream_done !== want.stream_done) begin
            if (err_cnt < 40)
              $display({"%0t: mismatch: sample exp %0d got %0d, run_last exp %0b got %0b, ",
                        "stream_done exp %0b got %0b"}, $time, $signed(want.smp),
                       $signed(got.smp), want.run_last, got.run_last, want.stream_done,
                       got.stream_done);
            err_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        idle_cnt = 0;
        in_acc_cnt++;
        mix_and_resample(chan_feed.pop_front());
      end
      if (psel && penable) idle_cnt = 0;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_STEP_RATIO: cfg_step       = val[STEP_BITS-1:0];
      REG_MIX_GAIN:   cfg_gain       = val[GAIN_BITS-1:0];
      REG_BYPASS:     cfg_bypass     = val[0];
      REG_MAX_FRAMES: cfg_max_frames = val[FRAME_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (chan_feed.size() != 0 || due_samples.size() != 0) @(posedge clk_i);
    // let a frame with no result finish in the sequencer
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [STEP_BITS-1:0] step, logic [GAIN_BITS-1:0] gain,
                          logic byp, logic [FRAME_BITS-1:0] maxf);
    wait_drained();
    apb_write(REG_STEP_RATIO, DATA_BITS'(step));
    apb_write(REG_MIX_GAIN, DATA_BITS'(gain));
    apb_write(REG_BYPASS, DATA_BITS'(byp));
    apb_write(REG_MAX_FRAMES, DATA_BITS'(maxf));
  endtask

  function automatic void feed(logic [SAMPLE_BITS-1:0] smp, logic fend, logic send);
    chan_item_t it;
    it.smp = smp;
    it.fend = fend;
    it.send = send;
    chan_feed.push_back(it);
  endfunction

  // Random frames; stream_end on inner channels is noise the block must ignore
  task automatic random_frames(int n_items);
    int cnt, nch;
    logic [SAMPLE_BITS-1:0] smp;
    bit send;
    cnt = 0;
    while (cnt < n_items) begin
      nch  = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
      send = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < nch; i++) begin
        case ($urandom_range(0, 7))
          0: smp = SAMPLE_BITS'(SMP_MAX);
          1: smp = SAMPLE_BITS'(SMP_MIN);
          2: smp = SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
          default: smp = SAMPLE_BITS'($urandom);
        endcase
        if (i == nch - 1) feed(smp, 1'b1, send);
        else feed(smp, 1'b0, 1'($urandom_range(0, 1)));
      end
      cnt += nch;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.channel_sample = '0;
    in_ch.frame_end = 1'b0;
    in_ch.stream_end = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_step = STEP_RESET;
    cfg_gain = GAIN_RESET;
    cfg_bypass = 1'b0;
    cfg_max_frames = FRAMES_RESET;
    m_dropping = 1'b0;
    clear_stream();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: first sample only held, saturated mix, sum clamp, ignored stream_end
    feed(SAMPLE_BITS'(SMP_MAX), 1'b1, 1'b0);
    feed(SAMPLE_BITS'(SMP_MIN), 1'b0, 1'b1);
    feed(SAMPLE_BITS'(SMP_MIN), 1'b1, 1'b0);
    for (int i = 0; i < 10; i++) feed(SAMPLE_BITS'(SMP_MAX), i == 9, 1'b0);
    feed('0, 1'b1, 1'b1);

    // Step below minimum, frame limit of zero: stream ends at once, then drop to stream_end
    set_regs(24'd1000, 16'd4096, 1'b0, 24'd0);
    feed(24'h400000, 1'b1, 1'b0);
    feed(24'h123456, 1'b1, 1'b0);
    feed(24'h654321, 1'b0, 1'b1);
    feed(24'h0F0F0F, 1'b1, 1'b1);

    // Step near the top of its range: no tail positions remain at stream end
    set_regs(24'd16711680, 16'd32768, 1'b0, 24'hFFFFFF);
    feed(24'd100, 1'b1, 1'b0);
    feed(-24'sd100, 1'b1, 1'b1);

    // Bypass
    set_regs(24'd65536, 16'd32768, 1'b1, 24'hFFFFFF);
    feed(24'd5, 1'b0, 1'b0);
    feed(-24'sd7, 1'b1, 1'b0);
    feed(24'd1, 1'b1, 1'b1);

    set_regs(24'd2048, 16'd16384, 1'b0, 24'hFFFFFF);
    random_frames(15);
    set_regs(24'd16711680, 16'd32768, 1'b0, 24'd5);
    random_frames(15);
    set_regs(24'd98304, 16'd4096, 1'b1, 24'd3);
    random_frames(15);
    set_regs(24'd1000, 16'd12000, 1'b0, 24'd0);
    random_frames(10);
    set_regs(STEP_BITS'($urandom_range(20000, 140000)),
             GAIN_BITS'($urandom_range(4096, 32768)), 1'b0, 24'hFFFFFF);
    // hold results back so the block fills up and stalls its input
    hold_req = LONG_HOLD;
    random_frames(30);
    set_regs(STEP_BITS'($urandom_range(2048, 200000)),
             GAIN_BITS'($urandom_range(4096, 32768)), 1'b0, 24'hFFFFFF);
    quiet_tail = 1'b1;
    random_frames(15);

    while (chan_feed.size() != 0 || due_samples.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (err_cnt == 0 && due_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
